### sv/aafd_pkg.sv
// shared types, constants and digit helpers for the ascii attitude frame decoder
// no dependencies; imported by the decoder top level and its port checker
`default_nettype none

package aafd_pkg;

    // payload bytes kept per frame (valid range 16..256)
    localparam int STORED_BYTES = 16;
    localparam int STORE_IDX_W  = (STORED_BYTES > 1) ? $clog2(STORED_BYTES) : 1;
    localparam int COUNT_W      = 9;

    localparam int BYTE_W   = 8;
    localparam int DIGIT_W  = 9;
    localparam int ANGLE_W  = 23;
    localparam int SIZE_W   = 16;
    localparam int SUM5_W   = 24;

    localparam int S_TDATA_W = 8;
    localparam int M_FIELD_W = 3 * ANGLE_W + 2 * SIZE_W + DIGIT_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0] CHAR_START = 8'h40;  // '@'
    localparam logic [BYTE_W-1:0] CHAR_END   = 8'h2A;  // '*'
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;  // ' '
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;  // '0'

    localparam logic [BYTE_W-1:0] TYPE_ATTITUDE = 8'h01;
    localparam logic [BYTE_W-1:0] TYPE_TARGET   = 8'h02;

    localparam logic KIND_ATTITUDE = 1'b0;
    localparam logic KIND_TARGET   = 1'b1;

    localparam logic signed [SUM5_W-1:0] PITCH_BIAS = 24'sd18000;
    localparam logic signed [SUM5_W-1:0] ROLL_BIAS  = 24'sd9000;
    localparam logic signed [SUM5_W-1:0] YAW_BIAS   = 24'sd18000;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_DATA = 4'b0100,
        PH_TAIL = 4'b1000
    } phase_t;

    // byte minus '0', space reads as zero, no range check
    function automatic logic signed [DIGIT_W-1:0] digit_of(input logic [BYTE_W-1:0] b);
        logic signed [DIGIT_W-1:0] d;
        d = (b == CHAR_SPACE) ? '0
                              : $signed({1'b0, b}) - $signed({1'b0, CHAR_ZERO});
        return d;
    endfunction

    function automatic logic signed [SUM5_W-1:0] sum5(
        input logic signed [DIGIT_W-1:0] d4,
        input logic signed [DIGIT_W-1:0] d3,
        input logic signed [DIGIT_W-1:0] d2,
        input logic signed [DIGIT_W-1:0] d1,
        input logic signed [DIGIT_W-1:0] d0
    );
        logic signed [SUM5_W-1:0] v;
        v = SUM5_W'(d4) * 24'sd10000 + SUM5_W'(d3) * 24'sd1000
          + SUM5_W'(d2) * 24'sd100 + SUM5_W'(d1) * 24'sd10 + SUM5_W'(d0);
        return v;
    endfunction

    function automatic logic signed [SIZE_W-1:0] sum3(
        input logic signed [DIGIT_W-1:0] d2,
        input logic signed [DIGIT_W-1:0] d1,
        input logic signed [DIGIT_W-1:0] d0
    );
        logic signed [SIZE_W-1:0] v;
        v = SIZE_W'(d2) * 16'sd100 + SIZE_W'(d1) * 16'sd10 + SIZE_W'(d0);
        return v;
    endfunction

endpackage

`default_nettype wire

### sv/ascii_attitude_frame_decoder.sv
// ascii attitude / target frame decoder: deframer, payload store and field decode
// depends on aafd_pkg for constants, the phase type and digit helpers
`default_nettype none

// usage
//   slave side (s_tvalid/s_tready/s_tdata) carries one received serial byte
//   per request. the parser deframes '@', a length byte L, L payload bytes
//   (L = 0 means 256) and a '*' trailer; any other byte in the trailer slot
//   drops the frame and the parser goes back to hunting for '@'.
//   master side (m_tvalid/m_tready/m_tdata/m_tuser) carries one decoded frame
//   per request: m_tuser = 0 for an attitude frame (pitch/roll/yaw), 1 for a
//   target frame (location/width). the held target number rides along in both.
//   frames with an unknown type byte give nothing.
// latency and throughput
//   one byte per cycle, sustained while no result sits unclaimed. a decoded frame shows on the master side
//   the cycle after its '*' is taken: the decode is one pass of constant
//   multiply-add logic from the payload registers into the output register.
// stall
//   the output register parts the two sides; bytes keep flowing while it is
//   empty or being drained, and s_tready drops only while a result sits
//   unclaimed in it.
// reset
//   aresetn low clears the parser to idle, the payload store and held number
//   to zero, and empties the output register.

module ascii_attitude_frame_decoder (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // slave side: [7:0] rx_byte
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [aafd_pkg::S_TDATA_W-1:0] s_tdata,
    // master side: [22:0] pitch, [45:23] roll, [68:46] yaw, [84:69] location,
    //              [100:85] width, [109:101] target_number, [111:110] zero
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [aafd_pkg::M_TDATA_W-1:0]     m_tdata,
    // master side user: [0] frame_kind
    output logic                               m_tuser
);
    import aafd_pkg::*;

    // parser state
    phase_t                         phase_reg, phase_next;
    logic [BYTE_W-1:0]              expected_last_reg, expected_last_next;
    logic [COUNT_W-1:0]             byte_count_reg, byte_count_next;
    logic [BYTE_W-1:0]              payload_store_reg [STORED_BYTES];
    logic signed [DIGIT_W-1:0]      held_number_reg, held_number_next;

    // output register
    logic                           m_valid_reg, m_valid_next;
    logic                           kind_reg;
    logic signed [ANGLE_W-1:0]      pitch_reg, roll_reg, yaw_reg;
    logic signed [SIZE_W-1:0]       location_reg, width_reg;
    logic signed [DIGIT_W-1:0]      number_reg;

    logic                           accept;
    logic [BYTE_W-1:0]              rx_byte;
    logic                           store_en;
    logic                           frame_done;
    logic                           is_att, is_tgt;
    logic                           load_result;

    // decode datapath
    logic signed [DIGIT_W-1:0]      dg [STORED_BYTES];
    logic signed [SUM5_W-1:0]       pitch_raw, roll_raw, yaw_raw;
    logic signed [SUM5_W-1:0]       pitch_val, roll_val, yaw_val;
    logic signed [SIZE_W-1:0]       loc_val, wid_val;
    logic signed [DIGIT_W-1:0]      num_digit;

    assign rx_byte  = s_tdata[BYTE_W-1:0];
    // take bytes unless a finished frame is stuck in the output register
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // ---------------- deframer ----------------
    assign store_en   = accept && (phase_reg == PH_DATA)
                     && (byte_count_reg < COUNT_W'(STORED_BYTES));
    assign frame_done = accept && (phase_reg == PH_TAIL) && (rx_byte == CHAR_END);

    always_comb begin
        phase_next         = phase_reg;
        expected_last_next = expected_last_reg;
        byte_count_next    = byte_count_reg;
        if (accept) begin
            case (phase_reg)
                PH_IDLE: begin
                    if (rx_byte == CHAR_START) begin
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN: begin
                    // length 0 wraps to 255 here, so 256 bytes are taken
                    expected_last_next = rx_byte - 8'd1;
                    byte_count_next    = '0;
                    phase_next         = PH_DATA;
                end
                PH_DATA: begin
                    if (byte_count_reg >= {1'b0, expected_last_reg}) begin
                        phase_next = PH_TAIL;
                    end
                    byte_count_next = byte_count_reg + 9'd1;
                end
                PH_TAIL: begin
                    // good or bad trailer, the parser hunts again
                    phase_next = PH_IDLE;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            expected_last_reg <= '0;
            byte_count_reg    <= '0;
            held_number_reg   <= '0;
        end else begin
            phase_reg         <= phase_next;
            expected_last_reg <= expected_last_next;
            byte_count_reg    <= byte_count_next;
            held_number_reg   <= held_number_next;
        end
    end

    // payload store: one write address, every entry read at its own place
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STORED_BYTES; i++) begin
                payload_store_reg[i] <= '0;
            end
        end else if (store_en) begin
            payload_store_reg[byte_count_reg[STORE_IDX_W-1:0]] <= rx_byte;
        end
    end

    // ---------------- field decode ----------------
    always_comb begin
        for (int i = 0; i < STORED_BYTES; i++) begin
            dg[i] = digit_of(payload_store_reg[i]);
        end
    end

    assign is_att = (payload_store_reg[0] == TYPE_ATTITUDE);
    assign is_tgt = (payload_store_reg[0] == TYPE_TARGET);

    assign pitch_raw = sum5(dg[1], dg[2], dg[3], dg[4], dg[5]);
    assign roll_raw  = sum5(dg[6], dg[7], dg[8], dg[9], dg[10]);
    assign yaw_raw   = sum5(dg[11], dg[12], dg[13], dg[14], dg[15]);

    // pitch is reported negated
    assign pitch_val = PITCH_BIAS - pitch_raw;
    assign roll_val  = roll_raw - ROLL_BIAS;
    assign yaw_val   = yaw_raw - YAW_BIAS;

    assign loc_val   = sum3(dg[1], dg[2], dg[3]);
    assign wid_val   = sum3(dg[4], dg[5], dg[6]);
    assign num_digit = dg[7];

    // target number only moves on a target frame with a nonzero digit
    assign held_number_next = (frame_done && is_tgt && (num_digit != '0))
                              ? num_digit : held_number_reg;

    assign load_result = frame_done && (is_att || is_tgt);

    // ---------------- output register ----------------
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_result) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_result) begin
            kind_reg     <= is_tgt ? KIND_TARGET : KIND_ATTITUDE;
            pitch_reg    <= is_att ? ANGLE_W'(pitch_val) : '0;
            roll_reg     <= is_att ? ANGLE_W'(roll_val)  : '0;
            yaw_reg      <= is_att ? ANGLE_W'(yaw_val)   : '0;
            location_reg <= is_tgt ? loc_val : '0;
            width_reg    <= is_tgt ? wid_val : '0;
            number_reg   <= held_number_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = M_TDATA_W'({number_reg, width_reg, location_reg,
                                  yaw_reg, roll_reg, pitch_reg});

endmodule

`default_nettype wire

### sv/aafd_port_checker.sv
// port-level checker for the ascii attitude frame decoder, bound to its top level
// depends on aafd_pkg for the trailer character and field widths
`default_nettype none

module aafd_port_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [aafd_pkg::S_TDATA_W-1:0] s_tdata,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [aafd_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                           m_tuser
);
    import aafd_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // the output register comes out of reset empty
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result present after reset");

    // a fresh result needs a trailer taken the cycle before
    a_fresh_from_trailer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !($past(m_tvalid) && !$past(m_tready))
        |-> $past(s_tvalid && s_tready && (s_tdata[7:0] == CHAR_END)))
        else $error("result without a trailer byte");

    // bytes are never refused while the output register is empty
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // target frames carry no attitude
    a_target_no_angles: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_TARGET) |-> (m_tdata[3*ANGLE_W-1:0] == '0))
        else $error("target frame with nonzero angles");

endmodule

bind ascii_attitude_frame_decoder aafd_port_checker u_aafd_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
